// ===== src/circular_stack_alu_macros.svh =====
// ----------------------------------------------------------------------------
// circular_stack_alu assertion macros
// Shared concurrent assertion forms, sampled on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_STACK_ALU_MACROS_SVH
`define CIRCULAR_STACK_ALU_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSALU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSALU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/csalu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_pkg
// Types, codes and defaults shared by the circular stack ALU.
// ----------------------------------------------------------------------------
package csalu_pkg;

  localparam int STACK_DEPTH_DEF = 8;
  localparam int WORD_WIDTH_DEF  = 32;
  localparam int ACTION_W        = 5;
  localparam int VALUE_W         = 32;
  localparam int KIND_W          = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LIT    = 5'd0,
    ACT_DUP    = 5'd1,
    ACT_OVER   = 5'd2,
    ACT_SWAP   = 5'd3,
    ACT_DROP   = 5'd4,
    ACT_ADD    = 5'd5,
    ACT_SUB    = 5'd6,
    ACT_MUL    = 5'd7,
    ACT_EQUAL  = 5'd8,
    ACT_LESS   = 5'd9,
    ACT_PRINT  = 5'd10,
    ACT_EMIT   = 5'd11,
    ACT_KEY    = 5'd12,
    ACT_CELL   = 5'd13,
    ACT_IFTEST = 5'd14,
    ACT_NOP    = 5'd15,
    ACT_HALT   = 5'd16
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_PRINT = 2'd1,
    KIND_EMIT  = 2'd2,
    KIND_HALT  = 2'd3
  } kind_t;

  // Stack movement for one instruction, with entry 0 as top of stack.
  typedef enum logic [2:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_SWAP,
    STK_FOLD
  } stk_op_t;

  typedef struct packed {
    stk_op_t stk_op;
    kind_t   kind;
    logic    skip;
  } ctrl_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  operand;
  } in_word_t;

  typedef struct packed {
    logic [KIND_W-1:0]  out_kind;
    logic [VALUE_W-1:0] out_value;
    logic               skip_next;
    logic [VALUE_W-1:0] top_word;
  } out_word_t;

endpackage

// ===== src/csalu_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_alu
// Instruction decode and word arithmetic on the two top stack entries.
// ----------------------------------------------------------------------------
module csalu_alu #(
  parameter int WORD_WIDTH = csalu_pkg::WORD_WIDTH_DEF
) (
  input  logic [csalu_pkg::ACTION_W-1:0] action,
  input  logic [csalu_pkg::VALUE_W-1:0]  operand,
  input  logic [WORD_WIDTH-1:0]          tos,
  input  logic [WORD_WIDTH-1:0]          nos,
  output csalu_pkg::ctrl_t               ctrl,
  output logic [WORD_WIDTH-1:0]          res,
  output logic [WORD_WIDTH-1:0]          val
);

  logic [WORD_WIDTH-1:0] op_word;

  assign op_word = WORD_WIDTH'(operand);

  always_comb begin
    ctrl.stk_op = csalu_pkg::STK_HOLD;
    ctrl.kind   = csalu_pkg::KIND_NONE;
    ctrl.skip   = 1'b0;
    res         = '0;
    val         = '0;
    unique case (action)
      csalu_pkg::ACT_LIT, csalu_pkg::ACT_KEY: begin
        ctrl.stk_op = csalu_pkg::STK_PUSH;
        res         = op_word;
      end
      csalu_pkg::ACT_DUP: begin
        ctrl.stk_op = csalu_pkg::STK_PUSH;
        res         = tos;
      end
      csalu_pkg::ACT_OVER: begin
        ctrl.stk_op = csalu_pkg::STK_PUSH;
        res         = nos;
      end
      csalu_pkg::ACT_CELL: begin
        ctrl.stk_op = csalu_pkg::STK_PUSH;
        res         = WORD_WIDTH'(WORD_WIDTH / 8);
      end
      csalu_pkg::ACT_SWAP: ctrl.stk_op = csalu_pkg::STK_SWAP;
      csalu_pkg::ACT_DROP: ctrl.stk_op = csalu_pkg::STK_POP;
      csalu_pkg::ACT_ADD: begin
        ctrl.stk_op = csalu_pkg::STK_FOLD;
        res         = nos + tos;
      end
      csalu_pkg::ACT_SUB: begin
        ctrl.stk_op = csalu_pkg::STK_FOLD;
        res         = nos - tos;
      end
      csalu_pkg::ACT_MUL: begin
        ctrl.stk_op = csalu_pkg::STK_FOLD;
        res         = nos * tos;
      end
      csalu_pkg::ACT_EQUAL: begin
        ctrl.stk_op = csalu_pkg::STK_FOLD;
        res         = WORD_WIDTH'(nos == tos);
      end
      csalu_pkg::ACT_LESS: begin
        ctrl.stk_op = csalu_pkg::STK_FOLD;
        res         = WORD_WIDTH'(nos < tos);
      end
      csalu_pkg::ACT_PRINT: begin
        ctrl.stk_op = csalu_pkg::STK_POP;
        ctrl.kind   = csalu_pkg::KIND_PRINT;
        val         = tos;
      end
      csalu_pkg::ACT_EMIT: begin
        ctrl.stk_op = csalu_pkg::STK_POP;
        ctrl.kind   = csalu_pkg::KIND_EMIT;
        val         = tos;
      end
      csalu_pkg::ACT_IFTEST: begin
        ctrl.stk_op = csalu_pkg::STK_POP;
        ctrl.skip   = (tos == '0);
      end
      csalu_pkg::ACT_HALT: ctrl.kind = csalu_pkg::KIND_HALT;
      default: ;  // nop and unused codes
    endcase
  end

endmodule

// ===== src/csalu_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csalu_stack
// Circular data stack kept as a rotating register ring, entry 0 on top.
// ----------------------------------------------------------------------------
module csalu_stack #(
  parameter int STACK_DEPTH = csalu_pkg::STACK_DEPTH_DEF,
  parameter int WORD_WIDTH  = csalu_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  csalu_pkg::ctrl_t      ctrl,
  input  logic [WORD_WIDTH-1:0] res,
  output logic [WORD_WIDTH-1:0] tos,
  output logic [WORD_WIDTH-1:0] nos,
  output logic [WORD_WIDTH-1:0] top_nxt
);

  logic [WORD_WIDTH-1:0] stk_r   [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] stk_nxt [STACK_DEPTH];

  // A push rotates the ring up, a pop rotates it down; the pointer is implicit.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_ent
    localparam int PREV = (i + STACK_DEPTH - 1) % STACK_DEPTH;
    localparam int NEXT = (i + 1) % STACK_DEPTH;
    always_comb begin
      unique case (ctrl.stk_op)
        csalu_pkg::STK_PUSH: stk_nxt[i] = (i == 0) ? res : stk_r[PREV];
        csalu_pkg::STK_POP:  stk_nxt[i] = stk_r[NEXT];
        csalu_pkg::STK_FOLD: stk_nxt[i] = (i == 0) ? res : stk_r[NEXT];
        csalu_pkg::STK_SWAP: stk_nxt[i] = (i == 0) ? stk_r[1] :
                                          (i == 1) ? stk_r[0] : stk_r[i];
        default:             stk_nxt[i] = stk_r[i];
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stk_r[i] <= '0;
      end else if (en) begin
        stk_r[i] <= stk_nxt[i];
      end
    end
  end

  assign tos     = stk_r[0];
  assign nos     = stk_r[1];
  assign top_nxt = stk_nxt[0];

endmodule

// ===== src/circular_stack_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_stack_alu
// Data-stack execution unit of a Forth-style machine on a circular stack.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                          Word
//  -------  -----------------------------  ---------------------------------
//  input    in_valid / in_stall / in_word  action, operand (one instruction)
//  result   out_valid / out_stall / out_word  out_kind, out_value, skip_next,
//                                          top_word (one per instruction)
//
//  Each instruction moves from the input register, through execute, into the
//  result register, one per clock without stalls. The execute cycle reads the
//  two top ring entries, runs the ALU and rotates the stack ring in place.
//  Reset clears the pipeline valids and all stack entries at once.
//  A stalled result holds its register; the input register then holds and
//  in_stall rises, while a free result side lets a new word enter each cycle.
//
module circular_stack_alu #(
  parameter int STACK_DEPTH = csalu_pkg::STACK_DEPTH_DEF,
  parameter int WORD_WIDTH  = csalu_pkg::WORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  csalu_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output csalu_pkg::out_word_t out_word
);

`include "circular_stack_alu_macros.svh"

  localparam int VW = csalu_pkg::VALUE_W;

  logic                 in_valid_r;
  csalu_pkg::in_word_t  in_r;
  logic                 out_valid_r;
  csalu_pkg::out_word_t out_r;
  logic                 exec_fire;

  csalu_pkg::ctrl_t      ctrl;
  logic [WORD_WIDTH-1:0] res;
  logic [WORD_WIDTH-1:0] val;
  logic [WORD_WIDTH-1:0] tos;
  logic [WORD_WIDTH-1:0] nos;
  logic [WORD_WIDTH-1:0] top_nxt;

  // Execute whenever an instruction waits and the result register can move.
  assign exec_fire = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = in_valid_r && !exec_fire;

  // Input register: advance when the held word executes or when empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_word;
    end
  end

  csalu_alu #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_alu (
    .action  (in_r.action),
    .operand (in_r.operand),
    .tos     (tos),
    .nos     (nos),
    .ctrl    (ctrl),
    .res     (res),
    .val     (val)
  );

  csalu_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (exec_fire),
    .ctrl    (ctrl),
    .res     (res),
    .tos     (tos),
    .nos     (nos),
    .top_nxt (top_nxt)
  );

  // Result register: load on execute, drop the valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_r.out_kind  <= ctrl.kind;
      out_r.out_value <= VW'(val);
      out_r.skip_next <= ctrl.skip;
      out_r.top_word  <= VW'(top_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Every executed instruction must show up in the result register.
  `CSALU_ASSERT_NEXT(a_fire_gives_result, exec_fire, out_valid_r, "executed word lost")
  // Input holds back only behind a stalled, full result register.
  `CSALU_ASSERT_NOW(a_stall_cause, in_stall, out_valid_r && out_stall && in_valid_r, "stall without cause")
  // An instruction that does not move the stack keeps its top entry.
  `CSALU_ASSERT_NEXT(a_hold_keeps_top, exec_fire && ctrl.stk_op == csalu_pkg::STK_HOLD, $stable(tos), "top changed on hold")
  // A skip request never travels with a print, emit or halt report.
  `CSALU_ASSERT_NOW(a_skip_alone, out_valid_r && out_r.skip_next, out_r.out_kind == csalu_pkg::KIND_NONE, "skip with report")

endmodule

// ===== verif/tb_circular_stack_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_stack_alu
// Drives instruction words into the stack ALU and checks every result word
// against a cycle-free model of the circular data stack kept in the bench.
// ----------------------------------------------------------------------------
module tb_circular_stack_alu;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int MAX_IDLE      = 17;
  localparam int LONG_HOLD     = 80;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ACTION_W      = csalu_pkg::ACTION_W;
  localparam int VALUE_W       = csalu_pkg::VALUE_W;
  localparam int FIRST_SPARE   = int'(csalu_pkg::ACT_HALT) + 1;
  localparam int LAST_CODE     = (1 << ACTION_W) - 1;
  localparam int RING_DEPTH    = csalu_pkg::STACK_DEPTH_DEF;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  csalu_pkg::in_word_t  in_word;
  logic                 out_valid;
  logic                 out_stall;
  csalu_pkg::out_word_t out_word;

  // Bench copy of the data stack: ring entries and the 3-bit pointer.
  logic [VALUE_W-1:0] stack_ring [RING_DEPTH];
  logic [2:0]         stack_ptr;

  // Result words predicted at input accept, oldest first.
  csalu_pkg::out_word_t predicted_words[$];

  int unsigned fail_count;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned cycle_count;
  int unsigned kind_seen [4];
  int unsigned skips_seen;

  // Idle controls set by the test tasks for the sender and the result receiver.
  bit          tx_random;
  bit          rx_random;
  int unsigned long_hold_cycles;

  circular_stack_alu u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stack model
  // --------------------------------------------------------------------------

  // Advance the pointer with wrap, then write the new top.
  function automatic void push_entry(logic [VALUE_W-1:0] v);
    stack_ptr             = stack_ptr + 3'd1;
    stack_ring[stack_ptr] = v;
  endfunction

  // Read the top, then move the pointer back with wrap.
  function automatic logic [VALUE_W-1:0] pop_entry();
    logic [VALUE_W-1:0] v;
    v         = stack_ring[stack_ptr];
    stack_ptr = stack_ptr - 3'd1;
    return v;
  endfunction

  // Execute one instruction on the model stack and return its result word.
  function automatic csalu_pkg::out_word_t step_stack_machine(csalu_pkg::in_word_t w);
    csalu_pkg::out_word_t r;
    logic [VALUE_W-1:0]   n1;
    logic [VALUE_W-1:0]   n2;
    r = '0;
    case (w.action)
      csalu_pkg::ACT_LIT, csalu_pkg::ACT_KEY: push_entry(w.operand);
      csalu_pkg::ACT_DUP: push_entry(stack_ring[stack_ptr]);
      csalu_pkg::ACT_OVER: begin
        n1 = pop_entry();
        n2 = pop_entry();
        push_entry(n2);
        push_entry(n1);
        push_entry(n2);
      end
      csalu_pkg::ACT_SWAP: begin
        n1 = pop_entry();
        n2 = pop_entry();
        push_entry(n1);
        push_entry(n2);
      end
      csalu_pkg::ACT_DROP: n1 = pop_entry();
      csalu_pkg::ACT_ADD: begin
        n1 = pop_entry();
        n2 = pop_entry();
        push_entry(n1 + n2);
      end
      csalu_pkg::ACT_SUB: begin
        n1 = pop_entry();
        n2 = pop_entry();
        push_entry(n2 - n1);
      end
      csalu_pkg::ACT_MUL: begin
        n1 = pop_entry();
        n2 = pop_entry();
        push_entry(n1 * n2);
      end
      csalu_pkg::ACT_EQUAL: begin
        n1 = pop_entry();
        n2 = pop_entry();
        push_entry((n1 == n2) ? VALUE_W'(1) : '0);
      end
      csalu_pkg::ACT_LESS: begin
        n1 = pop_entry();
        n2 = pop_entry();
        push_entry((n2 < n1) ? VALUE_W'(1) : '0);
      end
      csalu_pkg::ACT_PRINT: begin
        r.out_kind  = csalu_pkg::KIND_PRINT;
        r.out_value = pop_entry();
      end
      csalu_pkg::ACT_EMIT: begin
        r.out_kind  = csalu_pkg::KIND_EMIT;
        r.out_value = pop_entry();
      end
      csalu_pkg::ACT_CELL: push_entry(VALUE_W'(csalu_pkg::WORD_WIDTH_DEF / 8));
      csalu_pkg::ACT_IFTEST: begin
        n1          = pop_entry();
        r.skip_next = (n1 == '0);
      end
      csalu_pkg::ACT_HALT: r.out_kind = csalu_pkg::KIND_HALT;
      // nop and every spare code leave the stack alone
      default: ;
    endcase
    r.top_word = stack_ring[stack_ptr];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic int unsigned tx_gap();
    return tx_random ? $urandom_range(0, MAX_IDLE) : 0;
  endfunction

  // Bias operands toward the corners so compares and iftest go both ways.
  function automatic logic [VALUE_W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return VALUE_W'($urandom_range(0, 3));
      3:       return {1'b1, {(VALUE_W-1){1'b0}}};
      4:       return {1'b0, {(VALUE_W-1){1'b1}}};
      default: return $urandom;
    endcase
  endfunction

  // Present one word at the falling edge, hold it until accepted, then
  // record what the block must answer.
  task automatic send_instruction(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] opnd);
    int unsigned         gap;
    csalu_pkg::in_word_t w;
    gap       = tx_gap();
    w.action  = act;
    w.operand = opnd;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_words.push_back(step_stack_machine(w));
    words_sent++;
  endtask

  // Drop valid so the last word is not taken twice.
  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    while (predicted_words.size() != 0) @(posedge clk);
  endtask

  // One short program: mostly operands followed by an operation, sometimes
  // a raw instruction with any code, sometimes a spare code.
  task automatic send_program_fragment();
    int unsigned pick;
    int unsigned pushes;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      pushes = $urandom_range(0, 2);
      repeat (pushes) begin
        case ($urandom_range(0, 3))
          0:       send_instruction(csalu_pkg::ACT_KEY, pick_operand());
          1:       send_instruction(csalu_pkg::ACT_CELL, $urandom);
          default: send_instruction(csalu_pkg::ACT_LIT, pick_operand());
        endcase
      end
      send_instruction(ACTION_W'($urandom_range(int'(csalu_pkg::ACT_DUP),
                                                int'(csalu_pkg::ACT_HALT))), $urandom);
    end else if (pick < 9) begin
      send_instruction(ACTION_W'($urandom_range(0, LAST_CODE)), pick_operand());
    end else begin
      send_instruction(ACTION_W'($urandom_range(FIRST_SPARE, LAST_CODE)), $urandom);
    end
  endtask

  task automatic send_random_programs(int unsigned count);
    int unsigned stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) send_program_fragment();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Walk every operation at least once, starting with pops on the fresh stack.
  task automatic test_directed();
    tx_random = 1'b0;
    rx_random = 1'b0;
    send_instruction(csalu_pkg::ACT_DROP, '0);     // pop on empty stack wraps
    send_instruction(csalu_pkg::ACT_PRINT, '1);    // reads the cleared entry
    send_instruction(csalu_pkg::ACT_LIT, '1);
    send_instruction(csalu_pkg::ACT_LIT, VALUE_W'(1));
    send_instruction(csalu_pkg::ACT_ADD, '0);      // all ones plus one wraps to zero
    send_instruction(csalu_pkg::ACT_IFTEST, '0);   // zero popped: skip
    send_instruction(csalu_pkg::ACT_LIT, {1'b1, {(VALUE_W-1){1'b0}}});
    send_instruction(csalu_pkg::ACT_DUP, '0);
    send_instruction(csalu_pkg::ACT_MUL, '0);      // product overflows to zero
    send_instruction(csalu_pkg::ACT_LIT, VALUE_W'(1));
    send_instruction(csalu_pkg::ACT_SUB, '0);      // zero minus one
    send_instruction(csalu_pkg::ACT_LIT, VALUE_W'(5));
    send_instruction(csalu_pkg::ACT_LESS, '0);     // unsigned: all ones is not below 5
    send_instruction(csalu_pkg::ACT_LIT, VALUE_W'(7));
    send_instruction(csalu_pkg::ACT_LIT, VALUE_W'(7));
    send_instruction(csalu_pkg::ACT_EQUAL, '0);
    send_instruction(csalu_pkg::ACT_OVER, '0);
    send_instruction(csalu_pkg::ACT_SWAP, '0);
    send_instruction(csalu_pkg::ACT_KEY, 32'h0000_0041);
    send_instruction(csalu_pkg::ACT_EMIT, '0);
    send_instruction(csalu_pkg::ACT_CELL, '1);
    send_instruction(csalu_pkg::ACT_IFTEST, '0);   // nonzero popped: no skip
    send_instruction(csalu_pkg::ACT_NOP, '1);
    send_instruction(csalu_pkg::ACT_HALT, '1);     // stack left as is
    send_instruction(ACTION_W'(LAST_CODE), '1);    // spare code acts as nop
    send_instruction(ACTION_W'(FIRST_SPARE), '0);
    release_input();
    wait_all_results();
  endtask

  // Random programs with gaps drawn on both sides.
  task automatic test_random_programs();
    tx_random = 1'b1;
    rx_random = 1'b1;
    send_random_programs(900);
    release_input();
  endtask

  // Full rate, no idling on either side.
  task automatic test_streaming();
    tx_random = 1'b0;
    rx_random = 1'b0;
    send_random_programs(250);
    release_input();
  endtask

  // Hold the result side for a long stretch while words keep coming, so
  // the pipeline fills and in_stall rises.
  task automatic test_input_backpressure();
    tx_random        = 1'b0;
    rx_random        = 1'b0;
    long_hold_cycles = LONG_HOLD;
    send_random_programs(150);
    rx_random        = 1'b1;
    long_hold_cycles = LONG_HOLD;
    send_random_programs(100);
    release_input();
  endtask

  // Send in bursts and let the block drain completely between them.
  task automatic test_drain_pauses();
    tx_random = 1'b1;
    rx_random = 1'b1;
    repeat (18) begin
      send_random_programs($urandom_range(5, 25));
      release_input();
      wait_all_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Draw a stall after each taken word when rx_random is set, or serve a long hold request.
  initial begin : result_receiver
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      n = 0;
      if (long_hold_cycles != 0) begin
        n                = long_hold_cycles;
        long_hold_cycles = 0;
      end else if (rst_n && out_valid && !out_stall && rx_random) begin
        n = $urandom_range(0, MAX_IDLE);
      end
      if (n != 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each taken result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    csalu_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_words.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %h", $time, out_word);
        fail_count++;
      end else begin
        want = predicted_words.pop_front();
        check_field("out_kind", VALUE_W'(want.out_kind), VALUE_W'(out_word.out_kind));
        check_field("out_value", want.out_value, out_word.out_value);
        check_field("skip_next", VALUE_W'(want.skip_next), VALUE_W'(out_word.skip_next));
        check_field("top_word", want.top_word, out_word.top_word);
        kind_seen[want.out_kind]++;
        if (want.skip_next) skips_seen++;
        words_checked++;
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, predicted_words.size());
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_word          = '0;
    tx_random        = 1'b0;
    rx_random        = 1'b0;
    long_hold_cycles = 0;
    fail_count       = 0;
    words_sent       = 0;
    words_checked    = 0;
    cycle_count      = 0;
    skips_seen       = 0;
    kind_seen        = '{default: 0};
    foreach (stack_ring[i]) stack_ring[i] = '0;
    stack_ptr        = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_programs();
    test_streaming();
    test_input_backpressure();
    test_drain_pauses();

    // Let the last results out, then watch for strays.
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_words.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, predicted_words.size());
      fail_count++;
    end

    $display("Ran %0d instructions, checked %0d results in %0d cycles.",
             words_sent, words_checked, cycle_count);
    $display("Results: %0d plain, %0d print, %0d emit, %0d halt, %0d skips; %0d mismatches.",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], skips_seen, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
